>>> rtl/lds_pkg.sv
package lds_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int TRACK_BITS   = 16;
  localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int SEEK_W       = TRACK_BITS + 1;
  localparam int CFG_IDX_W    = 1;

  typedef logic [TRACK_BITS-1:0] track_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [SEEK_W-1:0]     seek_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOWARD_LOWER = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

endpackage

>>> rtl/lds_ram.sv
module lds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/look_disk_scheduler_unit.sv
// LOOK disk scheduler. Requests are loaded one per cycle through start_i/busy_o, up to
// MAX_REQUESTS per batch (further ones are dropped); the request marked batch_last_i
// starts serving, and busy_o stays high until the batch is done. Serving sweeps first
// toward the configured direction from start_head, nearest first, then the other side;
// requests equal to start_head are dropped. Each result costs one full scan of the
// request memory (one read per cycle on the single read port, then the registered read
// data and the take of the pick), and the reversal and the closing scan add one scan
// each. Results come out on result_strobe_o for one cycle each and cannot be stalled;
// an empty batch gives one result with served_valid_o low.
module look_disk_scheduler_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [lds_pkg::TRACK_BITS-1:0]   request_track_i,
  input  logic                             batch_last_i,
  input  logic                             cfg_we_i,
  input  logic [lds_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lds_pkg::TRACK_BITS-1:0]   cfg_wdata_i,
  output logic                             result_strobe_o,
  output logic [lds_pkg::TRACK_BITS-1:0]   served_track_o,
  output logic                             served_valid_o,
  output logic [lds_pkg::SEEK_W-1:0]       total_seek_o,
  output logic                             run_last_o
);
  import lds_pkg::*;

  state_e  state_q, state_d;
  track_t  start_head_q;
  logic    toward_lower_q;
  count_t  cnt_q, cnt_d;
  count_t  issue_q, issue_d;
  logic    rd_vld_q, rd_vld_d;
  idx_t    rd_idx_q, rd_idx_d;
  logic [MAX_REQUESTS-1:0] served_q, served_d;
  logic    lower_q, lower_d;
  logic    pass_q, pass_d;
  logic    found_q, found_d;
  track_t  best_q, best_d;
  idx_t    best_idx_q, best_idx_d;
  track_t  head_q, head_d;
  seek_t   seek_q, seek_d;
  logic    pend_vld_q, pend_vld_d;
  track_t  pend_trk_q, pend_trk_d;
  seek_t   pend_seek_q, pend_seek_d;
  logic    out_stb_d, out_vld_d, out_last_d;
  track_t  out_trk_d;
  seek_t   out_seek_d;

  logic    accept;
  logic    ram_we;
  track_t  ram_rdata;
  logic    cand;
  logic    scan_done;
  track_t  gap;
  seek_t   seek_new;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q == ST_SCAN);
  assign ram_we = accept && (cnt_q < count_t'(MAX_REQUESTS));

  lds_ram #(
    .WIDTH (TRACK_BITS),
    .DEPTH (MAX_REQUESTS)
  ) u_req_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (request_track_i),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_head_q   <= '0;
      toward_lower_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_HEAD:   start_head_q   <= cfg_wdata_i;
        CFG_TOWARD_LOWER: toward_lower_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // nearest unserved request strictly on the current side of the start head
  always_comb begin
    if (lower_q) begin
      cand = (ram_rdata < start_head_q) && (!found_q || (ram_rdata > best_q));
    end else begin
      cand = (ram_rdata > start_head_q) && (!found_q || (ram_rdata < best_q));
    end
    cand = cand && !served_q[rd_idx_q];
  end

  assign scan_done = (issue_q == cnt_q) && !rd_vld_q;
  assign gap       = (best_q > head_q) ? (best_q - head_q) : (head_q - best_q);
  assign seek_new  = seek_q + seek_t'(gap);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    served_d    = served_q;
    lower_d     = lower_q;
    pass_d      = pass_q;
    found_d     = found_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    head_d      = head_q;
    seek_d      = seek_q;
    pend_vld_d  = pend_vld_q;
    pend_trk_d  = pend_trk_q;
    pend_seek_d = pend_seek_q;
    out_stb_d   = 1'b0;
    out_vld_d   = served_valid_o;
    out_trk_d   = served_track_o;
    out_seek_d  = total_seek_o;
    out_last_d  = run_last_o;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (ram_we) begin
            cnt_d = cnt_q + count_t'(1);
          end
          if (batch_last_i) begin
            state_d    = ST_SCAN;
            issue_d    = '0;
            found_d    = 1'b0;
            served_d   = '0;
            lower_d    = toward_lower_q;
            pass_d     = 1'b0;
            head_d     = start_head_q;
            seek_d     = '0;
            pend_vld_d = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (issue_q != cnt_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = issue_q[IDX_W-1:0];
          issue_d  = issue_q + count_t'(1);
        end
        if (rd_vld_q && cand) begin
          found_d    = 1'b1;
          best_d     = ram_rdata;
          best_idx_d = rd_idx_q;
        end
        if (scan_done) begin
          issue_d = '0;
          found_d = 1'b0;
          if (found_q) begin
            // serve the pick; the previous one is now known not to be the last
            served_d[best_idx_q] = 1'b1;
            seek_d      = seek_new;
            head_d      = best_q;
            out_stb_d   = pend_vld_q;
            out_vld_d   = 1'b1;
            out_trk_d   = pend_trk_q;
            out_seek_d  = pend_seek_q;
            out_last_d  = 1'b0;
            pend_vld_d  = 1'b1;
            pend_trk_d  = best_q;
            pend_seek_d = seek_new;
          end else if (!pass_q) begin
            // reverse and sweep the other side
            pass_d  = 1'b1;
            lower_d = !lower_q;
          end else begin
            out_stb_d  = 1'b1;
            out_vld_d  = pend_vld_q;
            out_trk_d  = pend_vld_q ? pend_trk_q : '0;
            out_seek_d = pend_vld_q ? pend_seek_q : '0;
            out_last_d = 1'b1;
            pend_vld_d = 1'b0;
            cnt_d      = '0;
            served_d   = '0;
            seek_d     = '0;
            state_d    = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      cnt_q           <= '0;
      issue_q         <= '0;
      rd_vld_q        <= 1'b0;
      served_q        <= '0;
      lower_q         <= 1'b1;
      pass_q          <= 1'b0;
      found_q         <= 1'b0;
      head_q          <= '0;
      seek_q          <= '0;
      pend_vld_q      <= 1'b0;
      result_strobe_o <= 1'b0;
    end else begin
      state_q         <= state_d;
      cnt_q           <= cnt_d;
      issue_q         <= issue_d;
      rd_vld_q        <= rd_vld_d;
      served_q        <= served_d;
      lower_q         <= lower_d;
      pass_q          <= pass_d;
      found_q         <= found_d;
      head_q          <= head_d;
      seek_q          <= seek_d;
      pend_vld_q      <= pend_vld_d;
      result_strobe_o <= out_stb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q       <= rd_idx_d;
    best_q         <= best_d;
    best_idx_q     <= best_idx_d;
    pend_trk_q     <= pend_trk_d;
    pend_seek_q    <= pend_seek_d;
    served_valid_o <= out_vld_d;
    served_track_o <= out_trk_d;
    total_seek_o   <= out_seek_d;
    run_last_o     <= out_last_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= count_t'(MAX_REQUESTS))
    else $error("request count beyond store depth");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (count_t'(rd_idx_q) < cnt_q))
    else $error("read of an entry beyond the batch");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && run_last_o) |-> !busy_o)
    else $error("final result while still serving");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !served_valid_o) |-> (run_last_o && (total_seek_o == '0)))
    else $error("empty result not final or with travel");

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy_o))
    else $error("result without a batch being served");

endmodule

>>> test/tb_look_disk_scheduler_unit.sv
`timescale 1ns / 1ps

module tb_look_disk_scheduler_unit;

  typedef lds_pkg::track_t track_t;
  typedef lds_pkg::seek_t  seek_t;

  localparam int MAX_REQ       = lds_pkg::MAX_REQUESTS;
  localparam int SETTLE_CYCLES = 2 * (MAX_REQ + 2);
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 42;

  typedef struct {
    track_t track;
    logic   last;
  } request_t;

  typedef struct {
    track_t track;
    logic   valid;
    seek_t  seek;
    logic   last;
  } service_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start_i = 1'b0;
  logic                              busy_o;
  track_t                            request_track_i = '0;
  logic                              batch_last_i = 1'b0;
  logic                              cfg_we_i;
  logic [lds_pkg::CFG_IDX_W-1:0]     cfg_idx_i;
  logic [lds_pkg::TRACK_BITS-1:0]    cfg_wdata_i;
  logic                              result_strobe_o;
  track_t                            served_track_o;
  logic                              served_valid_o;
  seek_t                             total_seek_o;
  logic                              run_last_o;

  look_disk_scheduler_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .request_track_i (request_track_i),
    .batch_last_i    (batch_last_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_strobe_o (result_strobe_o),
    .served_track_o  (served_track_o),
    .served_valid_o  (served_valid_o),
    .total_seek_o    (total_seek_o),
    .run_last_o      (run_last_o)
  );

  request_t pending_requests[$];
  service_t expected_services[$];
  track_t   stored_tracks[$];

  track_t   cfg_head;
  bit       cfg_lower;
  int       send_idle_pct;
  int       mismatch_count = 0;
  int       requests_taken = 0;
  int       batches_served = 0;
  int       results_checked = 0;
  int       idle_cycles = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Walk the stored batch in LOOK order from the configured head and queue one
  // expected service per request, or the single empty-batch result.
  function automatic void serve_look_order();
    bit          taken[MAX_REQ];
    bit          sweep_lower;
    int          best;
    int          first_idx;
    track_t      pos;
    logic [17:0] travel;
    service_t    svc;
    foreach (taken[i]) taken[i] = 1'b0;
    first_idx   = expected_services.size();
    pos         = cfg_head;
    travel      = '0;
    sweep_lower = cfg_lower;
    for (int pass = 0; pass < 2; pass++) begin
      best = 0;
      while (best >= 0) begin
        best = -1;
        for (int i = 0; i < stored_tracks.size(); i++) begin
          if (!taken[i]) begin
            if (sweep_lower ? (stored_tracks[i] < cfg_head &&
                               (best < 0 || stored_tracks[i] > stored_tracks[best]))
                            : (stored_tracks[i] > cfg_head &&
                               (best < 0 || stored_tracks[i] < stored_tracks[best])))
              best = i;
          end
        end
        if (best >= 0) begin
          taken[best] = 1'b1;
          travel += (stored_tracks[best] > pos) ? stored_tracks[best] - pos
                                                : pos - stored_tracks[best];
          pos = stored_tracks[best];
          svc.track = pos;
          svc.valid = 1'b1;
          svc.seek  = travel[lds_pkg::SEEK_W-1:0];
          svc.last  = 1'b0;
          expected_services.insert(expected_services.size(), svc);
        end
      end
      sweep_lower = !sweep_lower;
    end
    if (expected_services.size() == first_idx) begin
      svc.track = '0;
      svc.valid = 1'b0;
      svc.seek  = '0;
      svc.last  = 1'b1;
      expected_services.insert(expected_services.size(), svc);
    end else begin
      expected_services[$].last = 1'b1;
    end
    stored_tracks.delete();
    batches_served++;
  endfunction

  function automatic void take_request(request_t req);
    if (stored_tracks.size() < MAX_REQ) stored_tracks.insert(stored_tracks.size(), req.track);
    if (req.last) serve_look_order();
    requests_taken++;
  endfunction

  // driver: predict on each transfer, then present the next request or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) take_request('{request_track_i, batch_last_i});
      if (!start_i || !busy_o) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          request_track_i <= pending_requests[0].track;
          batch_last_i    <= pending_requests[0].last;
          start_i         <= 1'b1;
          void'(pending_requests.pop_front());
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (expected_services.size() == 0) begin
        report_mismatch($sformatf("unexpected result track %h valid %b seek %0d last %b",
                                  served_track_o, served_valid_o, total_seek_o, run_last_o));
      end else begin
        if (served_track_o !== expected_services[0].track ||
            served_valid_o !== expected_services[0].valid ||
            total_seek_o   !== expected_services[0].seek  ||
            run_last_o     !== expected_services[0].last)
          report_mismatch($sformatf(
            "got track %h valid %b seek %0d last %b, want %h %b %0d %b",
            served_track_o, served_valid_o, total_seek_o, run_last_o,
            expected_services[0].track, expected_services[0].valid,
            expected_services[0].seek, expected_services[0].last));
        void'(expected_services.pop_front());
        results_checked++;
      end
    end
  end

  // watchdog: cycles without any transfer in or out
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_strobe_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_services.size());
        $display("look_disk_scheduler_unit verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [lds_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == lds_pkg::CFG_START_HEAD) cfg_head = data;
    else cfg_lower = data[0];
  endtask

  task automatic set_config(track_t head, bit lower);
    write_reg(lds_pkg::CFG_START_HEAD, head);
    write_reg(lds_pkg::CFG_TOWARD_LOWER, {15'b0, lower});
  endtask

  // hold until every request is in, every result is out and the block is quiet
  task automatic drain_and_settle();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || start_i || expected_services.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
  endtask

  task automatic push_request(track_t track, logic last);
    request_t req;
    req.track = track;
    req.last  = last;
    pending_requests.insert(pending_requests.size(), req);
  endtask

  task automatic queue_batch(int unsigned size, bit close);
    track_t prev;
    track_t trk;
    prev = cfg_head;
    for (int unsigned k = 0; k < size; k++) begin
      case ($urandom_range(9))
        0:       trk = cfg_head;
        1:       trk = prev;
        2:       trk = $urandom_range(1) ? '1 : '0;
        3:       trk = cfg_head + track_t'($urandom_range(6)) - track_t'(3);
        default: trk = track_t'($urandom);
      endcase
      push_request(trk, close && (k == size - 1));
      prev = trk;
    end
  endtask

  task automatic random_phase(track_t head, bit lower, int idle_pct, bit leave_open);
    int          queued;
    int unsigned size;
    int unsigned pick;
    send_idle_pct = idle_pct;
    set_config(head, lower);
    queued = 0;
    while (queued < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 70)      size = $urandom_range(8, 1);
      else if (pick < 85) size = $urandom_range(31, 9);
      else if (pick < 93) size = MAX_REQ;
      else                size = $urandom_range(MAX_REQ + 5, MAX_REQ + 1);
      queue_batch(size, 1'b1);
      queued += size;
    end
    // leave a batch half loaded so the next settings apply to it
    if (leave_open) queue_batch(3, 1'b0);
    drain_and_settle();
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = lds_pkg::CFG_START_HEAD;
    cfg_wdata_i     = '0;
    cfg_head        = '0;
    cfg_lower       = 1'b1;
    send_idle_pct   = 38;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: head mid-range, lower tracks first
    set_config(16'h8000, 1'b1);
    push_request(16'h8000, 1'b1);
    push_request(16'h0000, 1'b0);
    push_request(16'hFFFF, 1'b0);
    push_request(16'h8000, 1'b0);
    push_request(16'h7FFF, 1'b0);
    push_request(16'h8001, 1'b0);
    push_request(16'h1234, 1'b0);
    push_request(16'h1234, 1'b1);
    push_request(16'h9000, 1'b0);
    push_request(16'hA000, 1'b1);
    push_request(16'h0001, 1'b1);
    push_request(16'h8000, 1'b0);
    push_request(16'h8000, 1'b1);
    push_request(16'h5555, 1'b0);
    push_request(16'hAAAA, 1'b1);
    drain_and_settle();

    random_phase(16'h0000, 1'b1, 38, 1'b0);
    random_phase(16'hFFFF, 1'b0, 38, 1'b1);
    random_phase(track_t'($urandom), 1'b0, 50, 1'b0);
    random_phase(16'h0000, 1'b0, 50, 1'b0);
    random_phase(16'hFFFF, 1'b1, 0, 1'b0);
    random_phase(track_t'($urandom), 1'b1, 0, 1'b0);

    while (expected_services.size() != 0) begin
      report_mismatch($sformatf("result never seen: track %h valid %b",
                                expected_services[0].track, expected_services[0].valid));
      void'(expected_services.pop_front());
    end
    $display("requests transferred: %0d, batches served: %0d, results checked: %0d",
             requests_taken, batches_served, results_checked);
    $display("head at both track extremes and mid-range, both sweep directions, mismatches: %0d",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("look_disk_scheduler_unit verification clean");
    end else begin
      $display("look_disk_scheduler_unit verification failed");
    end
    $finish;
  end

endmodule
